// ===== hw/rtl/svd_pkg.sv =====
// ----------------------------------------------------------------------------
// svd_pkg
// Shared constants, cosine table and saturation helper of the sine vertex
// deformer.
// ----------------------------------------------------------------------------
package svd_pkg;

  localparam int NSTG    = 12;
  localparam int TAB_N   = 1024;
  localparam int TAB_AW  = 10;

  localparam longint TWO_PI_Q32 = 64'd26986075409;
  localparam logic [18:0] TWO_PI_Q = 19'((TWO_PI_Q32 + 64'd32768) >> 16);
  localparam logic [29:0] RECIP    = 30'((64'd1 << 48) / ((TWO_PI_Q32 + 64'd32768) >> 16));
  localparam logic [33:0] ARG_OFS  = 34'(64'd5216 * ((TWO_PI_Q32 + 64'd32768) >> 16));
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // ceil(2^51/125): exact floor(m/125) for any 44-bit m
  localparam logic [44:0] TICK_RECIP    = 45'((64'd1 << 51) / 64'd125 + 64'd1);
  localparam logic [21:0] TICK_RECIP_HI = TICK_RECIP[44:23];
  localparam logic [22:0] TICK_RECIP_LO = TICK_RECIP[22:0];

  typedef enum logic [2:0] {
    REG_GAIN_X    = 3'd0,
    REG_GAIN_Y    = 3'd1,
    REG_GAIN_Z    = 3'd2,
    REG_MAGNITUDE = 3'd3,
    REG_WAVE_LEN  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    CMD_VERTEX = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef logic signed [31:0] cos_tab_t [TAB_N];

  // shift-subtract quotient of a dividend below 2^40
  function automatic longint unsigned long_div(longint unsigned n, longint unsigned dv);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int i = 39; i >= 0; i--) begin
      rem = (rem << 1) | ((n >> i) & 64'd1);
      if (rem >= dv) begin
        rem = rem - dv;
        quo = quo | (64'd1 << i);
      end
    end
    return quo;
  endfunction

  function automatic longint taylor(longint unsigned x, bit odd);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned d;
    longint sum;
    x2   = (x * x) >> 30;
    term = odd ? x : (64'd1 << 30);
    d    = odd ? 64'd1 : 64'd0;
    sum  = 0;
    for (int i = 0; i < 14; i++) begin
      sum  = (i % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
      term = long_div((term * x2) >> 30, (d + 1) * (d + 2));
      d    = d + 2;
    end
    return sum;
  endfunction

  function automatic cos_tab_t build_tab();
    cos_tab_t tab;
    longint unsigned m;
    longint unsigned q;
    longint unsigned r;
    longint unsigned x;
    longint v;
    for (int k = 0; k < TAB_N; k++) begin
      m = 64'(4 * k);
      q = m >> TAB_AW;
      r = m & 64'(TAB_N - 1);
      x = (HALF_PI_Q30 * r) >> TAB_AW;
      case (q)
        0:       v = taylor(x, 1'b0);
        1:       v = -taylor(x, 1'b1);
        2:       v = -taylor(x, 1'b0);
        default: v = taylor(x, 1'b1);
      endcase
      tab[k] = v[31:0];
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_TAB = build_tab();

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage

// ===== hw/rtl/svd_if.sv =====
// ----------------------------------------------------------------------------
// svd interfaces
// Item, result and register write channels of the sine vertex deformer.
// ----------------------------------------------------------------------------
interface svd_item_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [31:0] coord_x;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_z;
  logic [15:0]        delta_ms;
  modport source (output valid, cmd, coord_x, coord_y, coord_z, delta_ms, input ready);
  modport sink   (input valid, cmd, coord_x, coord_y, coord_z, delta_ms, output ready);
endinterface

interface svd_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink   (input valid, out_x, out_y, out_z, output ready);
endinterface

interface svd_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [31:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== hw/rtl/svd_phase.sv =====
// ----------------------------------------------------------------------------
// svd_phase
// Phase accumulator: adds round(wave_length*delta_ms/1000) by reciprocal
// multiplication, wraps once by 2*pi and saturates.
// ----------------------------------------------------------------------------
module svd_phase import svd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] delta_ms,
  input  logic [30:0] wave_length,
  output logic        idle,
  output logic [31:0] phase
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_PART = 5'b00100,
    ST_SUM  = 5'b01000,
    ST_UPD  = 5'b10000
  } st_t;

  st_t         st;
  logic [15:0] dly;
  logic [46:0] num;
  logic [21:0] m_hi;
  logic [21:0] m_lo;
  logic [44:0] pp_ll;
  logic [43:0] pp_lh;
  logic [44:0] pp_hl;
  logic [43:0] pp_hh;
  logic [88:0] prod;
  logic [37:0] inc;
  logic [38:0] sum;
  logic [38:0] wrapped;

  assign idle = (st == ST_IDLE);
  assign m_hi = num[46:25];
  assign m_lo = num[24:3];

  always_comb begin
    prod    = {pp_hh, 45'b0} + 89'({pp_hl, 22'b0}) + 89'({pp_lh, 23'b0}) + 89'(pp_ll);
    sum     = {7'b0, phase} + {1'b0, inc};
    wrapped = (sum > 39'(TWO_PI_Q)) ? sum - 39'(TWO_PI_Q) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= ST_IDLE;
      phase <= '0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          if (start) begin
            dly <= delta_ms;
            st  <= ST_MUL;
          end
        end
        ST_MUL: begin
          num <= {16'b0, wave_length} * {31'b0, dly} + 47'd500;
          st  <= ST_PART;
        end
        ST_PART: begin
          pp_ll <= 45'(m_lo) * 45'(TICK_RECIP_LO);
          pp_lh <= 44'(m_lo) * 44'(TICK_RECIP_HI);
          pp_hl <= 45'(m_hi) * 45'(TICK_RECIP_LO);
          pp_hh <= 44'(m_hi) * 44'(TICK_RECIP_HI);
          st    <= ST_SUM;
        end
        ST_SUM: begin
          inc <= prod[88:51];
          st  <= ST_UPD;
        end
        ST_UPD: begin
          phase <= (wrapped[38:32] != '0) ? 32'hffffffff : wrapped[31:0];
          st    <= ST_IDLE;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/svd_lane.sv =====
// ----------------------------------------------------------------------------
// svd_lane
// One axis: gain and magnitude products, mod 2*pi reduction by reciprocal,
// table cosine with interpolation, final product and saturating add.
// ----------------------------------------------------------------------------
module svd_lane import svd_pkg::*; (
  input  logic               clk,
  input  logic [NSTG:1]      en,
  input  logic signed [31:0] coord,
  input  logic signed [31:0] gain,
  input  logic signed [31:0] magnitude,
  input  logic [31:0]        phase,
  output logic signed [31:0] res
);

  logic signed [31:0] c1, c2, c3, c4, c5, c6, c7, c8, c9, c10, c11;
  logic signed [31:0] t1_2, t2_4, t2_5, t2_6, t2_7, t2_8, t2_9, t2_10;
  logic signed [63:0] p1, p3, p11;
  logic [33:0]        u1, u2, u3;
  logic [63:0]        qm2;
  logic [34:0]        qp3;
  logic [18:0]        r4, r5, r6;
  logic [48:0]        rm5;
  logic [25:0]        te6, t7;
  logic [44:0]        tp6;
  logic signed [31:0] a8, b8, a9, cv10;
  logic [15:0]        f8;
  logic signed [49:0] dp9;

  logic [33:0]        rr;
  logic [44:0]        rem7;
  logic [TAB_AW-1:0]  idx, nxt;
  logic signed [32:0] diff;
  logic signed [63:0] fin;

  always_comb begin
    rr   = u3 - 34'(qp3);
    rem7 = {r6, 26'b0} - tp6;
    idx  = t7[25:16];
    nxt  = idx + TAB_AW'(1);
    diff = {b8[31], b8} - {a8[31], a8};
    fin  = ((p11 + 64'sd536870912) >>> 30) + 64'(c11);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c1 <= coord;
      p1 <= coord * gain;
      u1 <= {2'b0, phase} + 34'(coord) + ARG_OFS;
    end
    if (en[2]) begin
      c2   <= c1;
      t1_2 <= sat32((p1 + 64'sd32768) >>> 16);
      qm2  <= 64'(u1) * 64'(RECIP);
      u2   <= u1;
    end
    if (en[3]) begin
      c3  <= c2;
      p3  <= t1_2 * magnitude;
      qp3 <= 35'(qm2[63:48]) * 35'(TWO_PI_Q);
      u3  <= u2;
    end
    if (en[4]) begin
      c4   <= c3;
      t2_4 <= sat32((p3 + 64'sd32768) >>> 16);
      r4   <= (rr >= 34'(TWO_PI_Q)) ? 19'(rr - 34'(TWO_PI_Q)) : rr[18:0];
    end
    if (en[5]) begin
      c5   <= c4;
      t2_5 <= t2_4;
      rm5  <= 49'(r4) * 49'(RECIP);
      r5   <= r4;
    end
    if (en[6]) begin
      c6   <= c5;
      t2_6 <= t2_5;
      te6  <= rm5[47:22];
      tp6  <= 45'(rm5[47:22]) * 45'(TWO_PI_Q);
      r6   <= r5;
    end
    if (en[7]) begin
      c7   <= c6;
      t2_7 <= t2_6;
      t7   <= (rem7 >= 45'(TWO_PI_Q)) ? te6 + 26'd1 : te6;
    end
    if (en[8]) begin
      c8   <= c7;
      t2_8 <= t2_7;
      a8   <= COS_TAB[idx];
      b8   <= COS_TAB[nxt];
      f8   <= t7[15:0];
    end
    if (en[9]) begin
      c9   <= c8;
      t2_9 <= t2_8;
      a9   <= a8;
      dp9  <= 50'(diff) * 50'(signed'({1'b0, f8}));
    end
    if (en[10]) begin
      c10   <= c9;
      t2_10 <= t2_9;
      cv10  <= a9 + dp9[47:16];
    end
    if (en[11]) begin
      c11 <= c10;
      p11 <= t2_10 * cv10;
    end
    if (en[12]) begin
      res <= sat32(fin);
    end
  end

endmodule

// ===== hw/rtl/sine_vertex_deform.sv =====
// ----------------------------------------------------------------------------
// sine_vertex_deform
// Deforms vertices by c + c*gain*magnitude*cos(phase + c); tick requests
// advance the phase.
//
//   channel  role  carries
//   item     sink  cmd, coord_x/y/z, delta_ms
//   result   src   out_x/y/z
//   cfg      sink  addr, data (gains, magnitude, wave_length)
//
// One vertex request per cycle unless back-pressure or a tick update holds it.
// A tick request holds item.ready low through the product, the partial
// products of the multiply by 1/1000, their sum, and the phase write.
// Each stage advances when it is empty or its successor advances, so
// bubbles collapse behind a stalled result. Reset clears valids and phase.
// ----------------------------------------------------------------------------
module sine_vertex_deform import svd_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  svd_item_if.sink     item,
  svd_result_if.source result,
  svd_cfg_if.sink      cfg
);

  logic signed [31:0] gain_x, gain_y, gain_z, magnitude;
  logic [30:0]        wave_length;
  logic [NSTG:1]      vld;
  logic [NSTG:1]      en;
  logic               ph_idle;
  logic [31:0]        phase;
  logic               vtx_acc;
  logic               tick_acc;

  always_comb begin
    en[NSTG] = !vld[NSTG] || result.ready;
    for (int i = NSTG - 1; i >= 1; i--) en[i] = !vld[i] || en[i + 1];
  end

  assign item.ready   = en[1] && ph_idle;
  assign vtx_acc      = item.valid && item.ready && (item.cmd == CMD_VERTEX);
  assign tick_acc     = item.valid && item.ready && (item.cmd == CMD_TICK);
  assign cfg.ready    = 1'b1;
  assign result.valid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= vtx_acc;
      for (int i = 2; i <= NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x      <= 32'sd65536;
      gain_y      <= 32'sd65536;
      gain_z      <= 32'sd65536;
      magnitude   <= 32'sd65536;
      wave_length <= 31'd65536;
    end else if (cfg.valid) begin
      unique case (cfg.addr)
        REG_GAIN_X:    gain_x      <= cfg.data;
        REG_GAIN_Y:    gain_y      <= cfg.data;
        REG_GAIN_Z:    gain_z      <= cfg.data;
        REG_MAGNITUDE: magnitude   <= cfg.data;
        REG_WAVE_LEN:  wave_length <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  svd_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .start       (tick_acc),
    .delta_ms    (item.delta_ms),
    .wave_length (wave_length),
    .idle        (ph_idle),
    .phase       (phase)
  );

  svd_lane u_lane_x (
    .clk(clk), .en(en), .coord(item.coord_x), .gain(gain_x),
    .magnitude(magnitude), .phase(phase), .res(result.out_x)
  );

  svd_lane u_lane_y (
    .clk(clk), .en(en), .coord(item.coord_y), .gain(gain_y),
    .magnitude(magnitude), .phase(phase), .res(result.out_y)
  );

  svd_lane u_lane_z (
    .clk(clk), .en(en), .coord(item.coord_z), .gain(gain_z),
    .magnitude(magnitude), .phase(phase), .res(result.out_z)
  );

`ifndef SYNTH
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    !ph_idle |-> !item.ready) else $error("item taken during phase update");
  a_tick_starts: assert property (@(posedge clk) disable iff (rst)
    tick_acc |=> !ph_idle) else $error("tick did not start phase update");
  a_vtx_enters: assert property (@(posedge clk) disable iff (rst)
    vtx_acc |=> vld[1]) else $error("vertex lost at pipeline entry");
`endif

endmodule
